>>> hdl/spc_pkg.sv
// Package: screen constants, command and mode codes, payload and axis result types.
`default_nettype none
package spc_pkg;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 200;

  // Signed working width: holds a 16-bit position plus or minus a screen extent.
  localparam int CALC_W = 18;

  typedef enum logic [2:0] {
    ACT_SET_POS   = 3'd0,
    ACT_SET_DX    = 3'd1,
    ACT_SET_DY    = 3'd2,
    ACT_SET_MODE  = 3'd3,
    ACT_DRAW      = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    MODE_CLAMP  = 2'd0,
    MODE_CENTRE = 2'd1,
    MODE_INSIDE = 2'd2,
    MODE_WRAP   = 2'd3
  } mode_e;

  // Drift codes; code three is stored but moves nothing.
  localparam logic [1:0] DRIFT_NONE  = 2'd0;
  localparam logic [1:0] DRIFT_PLUS  = 2'd1;
  localparam logic [1:0] DRIFT_MINUS = 2'd2;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;
    logic [1:0]         drift_dir;
    logic [1:0]         mode_value;
    logic [8:0]         sprite_width;
    logic [7:0]         sprite_height;
  } cmd_t;

  typedef struct packed {
    logic [8:0]         dest_x;
    logic [7:0]         dest_y;
    logic [8:0]         src_x;
    logic [7:0]         src_y;
    logic [8:0]         copy_w;
    logic [7:0]         copy_h;
    logic signed [15:0] placed_x;
    logic signed [15:0] placed_y;
  } res_t;

  typedef struct packed {
    logic signed [CALC_W-1:0] pos;
    logic signed [CALC_W-1:0] dst;
    logic signed [CALC_W-1:0] src;
    logic signed [CALC_W-1:0] ext;
  } axis_res_t;

endpackage
`default_nettype wire

>>> hdl/spc_cmd_if.sv
// Interface: command channel into the sprite placement unit.
`default_nettype none
interface spc_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [15:0] new_x;
  logic signed [15:0] new_y;
  logic [1:0]         drift_dir;
  logic [1:0]         mode_value;
  logic [8:0]         sprite_width;
  logic [7:0]         sprite_height;

  modport source (
    output valid, action, new_x, new_y, drift_dir, mode_value, sprite_width,
           sprite_height,
    input  ready
  );
  modport sink (
    input  valid, action, new_x, new_y, drift_dir, mode_value, sprite_width,
           sprite_height,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/spc_res_if.sv
// Interface: placement result channel out of the sprite placement unit.
`default_nettype none
interface spc_res_if;
  logic               valid;
  logic               ready;
  logic [8:0]         dest_x;
  logic [7:0]         dest_y;
  logic [8:0]         src_x;
  logic [7:0]         src_y;
  logic [8:0]         copy_w;
  logic [7:0]         copy_h;
  logic signed [15:0] placed_x;
  logic signed [15:0] placed_y;

  modport source (
    output valid, dest_x, dest_y, src_x, src_y, copy_w, copy_h, placed_x, placed_y,
    input  ready
  );
  modport sink (
    input  valid, dest_x, dest_y, src_x, src_y, copy_w, copy_h, placed_x, placed_y,
    output ready
  );
endinterface
`default_nettype wire

>>> hdl/sprite_place_and_clip.sv
// Top level: sprite placement unit with command register, placement logic and result register.
//
//   channel  dir  payload                                           word moves when
//   cmd_i    in   action new_x new_y drift_dir mode_value size      valid && ready
//   res_o    out  dest_x/y src_x/y copy_w/h placed_x/y              valid && ready
//
// A command is taken into the command register and applied to the state when
// it leaves that register; a draw's result loads into the result register at
// that same edge, and its handshake is offered from the result register. One
// word per cycle is sustained while results are taken: the state update and
// both axis placements sit in the combinational logic between the registers.
// Reset clears position and drift and selects auto centre.
// A held result stalls a draw in the command register and every word behind
// it; a command that is not a draw still retires while the result waits.
`default_nettype none
module sprite_place_and_clip (
  input  var logic  clk_i,
  input  var logic  rst_ni,
  spc_cmd_if.sink   cmd_i,
  spc_res_if.source res_o
);

  // command register
  spc_pkg::cmd_t  cmd_q;
  logic           cmd_valid_q;
  logic           is_draw;
  logic           advance;

  // placement state
  logic signed [15:0] pos_x_q, pos_x_d;
  logic signed [15:0] pos_y_q, pos_y_d;
  logic [1:0]         drift_x_q, drift_x_d;
  logic [1:0]         drift_y_q, drift_y_d;
  spc_pkg::mode_e     mode_q, mode_d;

  // result register
  spc_pkg::res_t  res_q;
  logic           res_valid_q;

  logic signed [15:0]  px_drift;
  logic signed [15:0]  py_drift;
  logic signed [spc_pkg::CALC_W-1:0] w_raw, h_raw, w_sat, h_sat;
  logic signed [spc_pkg::CALC_W-1:0] scr_w, scr_h;
  logic                 moving;
  spc_pkg::axis_res_t   x_res, y_res;

  function automatic logic signed [15:0] drift_step(input logic signed [15:0] p,
                                                    input logic [1:0] d);
    logic signed [15:0] r;
    case (d)
      spc_pkg::DRIFT_PLUS:  r = p + 16'sd1;
      spc_pkg::DRIFT_MINUS: r = p - 16'sd1;
      default:              r = p;
    endcase
    return r;
  endfunction

  // a draw waits for the result slot; everything else passes through
  assign is_draw = (spc_pkg::action_e'(cmd_q.action) == spc_pkg::ACT_DRAW);
  assign advance = cmd_valid_q && (!is_draw || !res_valid_q || res_o.ready);
  assign cmd_i.ready = !cmd_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
    end else if (cmd_i.ready) begin
      cmd_valid_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      cmd_q.action        <= cmd_i.action;
      cmd_q.new_x         <= cmd_i.new_x;
      cmd_q.new_y         <= cmd_i.new_y;
      cmd_q.drift_dir     <= cmd_i.drift_dir;
      cmd_q.mode_value    <= cmd_i.mode_value;
      cmd_q.sprite_width  <= cmd_i.sprite_width;
      cmd_q.sprite_height <= cmd_i.sprite_height;
    end
  end

  // drift first, then place
  assign px_drift = drift_step(pos_x_q, drift_x_q);
  assign py_drift = drift_step(pos_y_q, drift_y_q);

  assign scr_w = spc_pkg::CALC_W'(spc_pkg::SCREEN_W);
  assign scr_h = spc_pkg::CALC_W'(spc_pkg::SCREEN_H);
  assign w_raw = spc_pkg::CALC_W'(cmd_q.sprite_width);
  assign h_raw = spc_pkg::CALC_W'(cmd_q.sprite_height);
  // oversized sprites saturate to the screen
  assign w_sat = (w_raw > scr_w) ? scr_w : w_raw;
  assign h_sat = (h_raw > scr_h) ? scr_h : h_raw;

  spc_place_axis u_axis_x (
    .mode_i   (mode_q),
    .pos_i    (spc_pkg::CALC_W'(px_drift)),
    .size_i   (w_sat),
    .screen_i (scr_w),
    .res_o    (x_res)
  );

  spc_place_axis u_axis_y (
    .mode_i   (mode_q),
    .pos_i    (spc_pkg::CALC_W'(py_drift)),
    .size_i   (h_sat),
    .screen_i (scr_h),
    .res_o    (y_res)
  );

  assign moving = (cmd_q.drift_dir == spc_pkg::DRIFT_PLUS) ||
                  (cmd_q.drift_dir == spc_pkg::DRIFT_MINUS);

  always_comb begin
    pos_x_d   = pos_x_q;
    pos_y_d   = pos_y_q;
    drift_x_d = drift_x_q;
    drift_y_d = drift_y_q;
    mode_d    = mode_q;
    if (advance) begin
      case (spc_pkg::action_e'(cmd_q.action))
        spc_pkg::ACT_SET_POS: begin
          pos_x_d = cmd_q.new_x;
          pos_y_d = cmd_q.new_y;
          if (mode_q == spc_pkg::MODE_CENTRE) mode_d = spc_pkg::MODE_CLAMP;
        end
        spc_pkg::ACT_SET_DX: begin
          drift_x_d = cmd_q.drift_dir;
          if (moving && mode_q == spc_pkg::MODE_CENTRE) mode_d = spc_pkg::MODE_CLAMP;
        end
        spc_pkg::ACT_SET_DY: begin
          drift_y_d = cmd_q.drift_dir;
          if (moving && mode_q == spc_pkg::MODE_CENTRE) mode_d = spc_pkg::MODE_CLAMP;
        end
        spc_pkg::ACT_SET_MODE: begin
          mode_d = spc_pkg::mode_e'(cmd_q.mode_value);
        end
        spc_pkg::ACT_DRAW: begin
          pos_x_d = x_res.pos[15:0];
          pos_y_d = y_res.pos[15:0];
        end
        default: begin
          // unknown action: no effect
          mode_d = mode_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= '0;
      pos_y_q   <= '0;
      drift_x_q <= spc_pkg::DRIFT_NONE;
      drift_y_q <= spc_pkg::DRIFT_NONE;
      mode_q    <= spc_pkg::MODE_CENTRE;
    end else begin
      pos_x_q   <= pos_x_d;
      pos_y_q   <= pos_y_d;
      drift_x_q <= drift_x_d;
      drift_y_q <= drift_y_d;
      mode_q    <= mode_d;
    end
  end

  // result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance && is_draw) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_draw) begin
      res_q.dest_x   <= x_res.dst[8:0];
      res_q.dest_y   <= y_res.dst[7:0];
      res_q.src_x    <= x_res.src[8:0];
      res_q.src_y    <= y_res.src[7:0];
      res_q.copy_w   <= x_res.ext[8:0];
      res_q.copy_h   <= y_res.ext[7:0];
      res_q.placed_x <= x_res.pos[15:0];
      res_q.placed_y <= y_res.pos[15:0];
    end
  end

  assign res_o.valid    = res_valid_q;
  assign res_o.dest_x   = res_q.dest_x;
  assign res_o.dest_y   = res_q.dest_y;
  assign res_o.src_x    = res_q.src_x;
  assign res_o.src_y    = res_q.src_y;
  assign res_o.copy_w   = res_q.copy_w;
  assign res_o.copy_h   = res_q.copy_h;
  assign res_o.placed_x = res_q.placed_x;
  assign res_o.placed_y = res_q.placed_y;

endmodule
`default_nettype wire

>>> hdl/spc_place_axis.sv
// Module: placement and clipping of one axis by the current mode.
`default_nettype none
module spc_place_axis (
  input  var spc_pkg::mode_e                    mode_i,
  input  var logic signed [spc_pkg::CALC_W-1:0] pos_i,
  input  var logic signed [spc_pkg::CALC_W-1:0] size_i,
  input  var logic signed [spc_pkg::CALC_W-1:0] screen_i,
  output spc_pkg::axis_res_t                    res_o
);

  logic signed [spc_pkg::CALC_W-1:0] lim;
  logic signed [spc_pkg::CALC_W-1:0] neg_size;
  logic signed [spc_pkg::CALC_W-1:0] v1;
  logic signed [spc_pkg::CALC_W-1:0] v;
  logic signed [spc_pkg::CALC_W-1:0] s;
  logic signed [spc_pkg::CALC_W-1:0] e;

  assign lim      = screen_i - size_i;
  assign neg_size = -size_i;

  always_comb begin
    v1 = pos_i;
    v  = pos_i;
    s  = '0;
    e  = size_i;
    case (mode_i)
      spc_pkg::MODE_CENTRE: begin
        v = (screen_i >>> 1) - (size_i >>> 1);
      end
      spc_pkg::MODE_INSIDE: begin
        v1 = (pos_i > lim) ? lim : pos_i;
        v  = (v1 < 0) ? '0 : v1;
      end
      spc_pkg::MODE_WRAP, spc_pkg::MODE_CLAMP: begin
        if (mode_i == spc_pkg::MODE_WRAP) begin
          // off the far edge reappears before the near one, and back
          v1 = (pos_i > screen_i) ? neg_size : pos_i;
          v  = (v1 < neg_size) ? screen_i : v1;
        end else begin
          v1 = (pos_i > screen_i) ? screen_i : pos_i;
          v  = (v1 < neg_size) ? neg_size : v1;
        end
        if (v > lim) begin
          e = screen_i - v;
        end else if (v < 0) begin
          e = v + size_i;
          s = -v;
        end else begin
          e = size_i;
        end
      end
      default: begin
        v = pos_i;
      end
    endcase
  end

  assign res_o.pos = v;
  assign res_o.dst = v + s;
  assign res_o.src = s;
  assign res_o.ext = e;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Testbench for sprite_place_and_clip: random command words against a placement predictor.
`timescale 1ns / 100ps

module testbench;
  import spc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1000;
  localparam int MAX_REPORTS = 200;

  // Predicts every draw and queues the placement the block owes for it.
  class placement_tracker;
    logic signed [15:0] pos_x, pos_y;
    logic [1:0]         drift_x, drift_y;
    mode_e              mode;
    res_t               due[$];
    int                 mismatches;

    function new();
      pos_x = '0;
      pos_y = '0;
      drift_x = DRIFT_NONE;
      drift_y = DRIFT_NONE;
      mode = MODE_CENTRE;
      mismatches = 0;
    endfunction

    // One axis: v is updated in place, gives origin, offset and extent.
    function void place_axis(input mode_e m, inout int v, input int size,
                             input int span, output int dst, output int off,
                             output int ext);
      off = 0;
      if (m == MODE_CENTRE || m == MODE_INSIDE) begin
        if (m == MODE_CENTRE) begin
          v = span / 2 - size / 2;
        end else begin
          if (v > span - size) v = span - size;
          if (v < 0) v = 0;
        end
        ext = size;
      end else begin
        if (m == MODE_WRAP) begin
          if (v > span) v = -size;
          if (v < -size) v = span;
        end else begin
          if (v > span) v = span;
          if (v < -size) v = -size;
        end
        if (v > span - size) begin
          ext = span - v;
        end else if (v < 0) begin
          ext = v + size;
          off = -v;
        end else begin
          ext = size;
        end
      end
      dst = v + off;
    endfunction

    function void note_word(cmd_t c);
      int   w, h, x, y, dx, dy, sx, sy, cw, ch;
      logic moving;
      res_t r;
      moving = (c.drift_dir == DRIFT_PLUS || c.drift_dir == DRIFT_MINUS);
      case (c.action)
        ACT_SET_POS: begin
          pos_x = c.new_x;
          pos_y = c.new_y;
          if (mode == MODE_CENTRE) mode = MODE_CLAMP;
        end
        ACT_SET_DX: begin
          drift_x = c.drift_dir;
          if (moving && mode == MODE_CENTRE) mode = MODE_CLAMP;
        end
        ACT_SET_DY: begin
          drift_y = c.drift_dir;
          if (moving && mode == MODE_CENTRE) mode = MODE_CLAMP;
        end
        ACT_SET_MODE: mode = mode_e'(c.mode_value);
        ACT_DRAW: begin
          w = c.sprite_width;
          h = c.sprite_height;
          if (w > SCREEN_W) w = SCREEN_W;
          if (h > SCREEN_H) h = SCREEN_H;
          if (drift_x == DRIFT_PLUS) pos_x = 16'(pos_x + 1);
          else if (drift_x == DRIFT_MINUS) pos_x = 16'(pos_x - 1);
          if (drift_y == DRIFT_PLUS) pos_y = 16'(pos_y + 1);
          else if (drift_y == DRIFT_MINUS) pos_y = 16'(pos_y - 1);
          x = pos_x;
          y = pos_y;
          place_axis(mode, x, w, SCREEN_W, dx, sx, cw);
          place_axis(mode, y, h, SCREEN_H, dy, sy, ch);
          pos_x = x[15:0];
          pos_y = y[15:0];
          r.dest_x = dx[8:0];
          r.dest_y = dy[7:0];
          r.src_x = sx[8:0];
          r.src_y = sy[7:0];
          r.copy_w = cw[8:0];
          r.copy_h = ch[7:0];
          r.placed_x = pos_x;
          r.placed_y = pos_y;
          due.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
      if (want !== seen) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, seen);
        mismatches++;
      end
    endfunction

    function void check_placement(res_t got);
      res_t want;
      if (due.size() == 0) begin
        if (mismatches < MAX_REPORTS)
          $display("%0t: placement word with none expected, got %p", $time, got);
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare_field("dest_x", want.dest_x, got.dest_x);
      compare_field("dest_y", want.dest_y, got.dest_y);
      compare_field("src_x", want.src_x, got.src_x);
      compare_field("src_y", want.src_y, got.src_y);
      compare_field("copy_w", want.copy_w, got.copy_w);
      compare_field("copy_h", want.copy_h, got.copy_h);
      compare_field("placed_x", want.placed_x, got.placed_x);
      compare_field("placed_y", want.placed_y, got.placed_y);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   send_burst;
  placement_tracker tracker;

  spc_cmd_if cmd_bus ();
  spc_res_if res_bus ();

  sprite_place_and_clip uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .res_o  (res_bus)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Hang guard: nothing in a correct run comes near this.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle cycles before the next word: mostly 0..11, with bursts of
  // back-to-back words so that full-rate stretches occur too.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  function automatic cmd_t mk(logic [2:0] act, int x, int y, logic [1:0] dir,
                              logic [1:0] md, int w, int h);
    cmd_t c;
    c.action = act;
    c.new_x = x[15:0];
    c.new_y = y[15:0];
    c.drift_dir = dir;
    c.mode_value = md;
    c.sprite_width = w[8:0];
    c.sprite_height = h[7:0];
    return c;
  endfunction

  // Random command word. Fields not used by the action stay random so every bit
  // toggles; positions mostly fall in a band around the screen, sizes within it.
  function automatic cmd_t rand_word();
    cmd_t c;
    int   pick, vx, vy;
    c.new_x = 16'($urandom);
    c.new_y = 16'($urandom);
    c.drift_dir = 2'($urandom);
    c.mode_value = 2'($urandom);
    c.sprite_width = 9'($urandom);
    c.sprite_height = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c.action = ACT_DRAW;
      if ($urandom_range(0, 7) != 0) begin
        c.sprite_width = 9'($urandom_range(1, SCREEN_W));
        c.sprite_height = 8'($urandom_range(1, SCREEN_H));
      end
    end else if (pick < 64) begin
      c.action = ACT_SET_POS;
      if ($urandom_range(0, 3) != 0) begin
        vx = int'($urandom_range(0, 1100)) - 400;
        vy = int'($urandom_range(0, 700)) - 300;
        c.new_x = vx[15:0];
        c.new_y = vy[15:0];
      end
    end else if (pick < 72) begin
      c.action = ACT_SET_DX;
    end else if (pick < 80) begin
      c.action = ACT_SET_DY;
    end else if (pick < 93) begin
      c.action = ACT_SET_MODE;
    end else begin
      // undefined action codes above draw: block must ignore them
      c.action = ACT_DRAW | 3'($urandom_range(1, 3));
    end
    return c;
  endfunction

  // Offer one word after a random gap; valid stays up across back-to-back words.
  task automatic send_word(input cmd_t c);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_bus.valid <= 1'b1;
    cmd_bus.action <= c.action;
    cmd_bus.new_x <= c.new_x;
    cmd_bus.new_y <= c.new_y;
    cmd_bus.drift_dir <= c.drift_dir;
    cmd_bus.mode_value <= c.mode_value;
    cmd_bus.sprite_width <= c.sprite_width;
    cmd_bus.sprite_height <= c.sprite_height;
    do @(posedge clk_i); while (!cmd_bus.ready);
    tracker.note_word(c);
  endtask

  // Result side: random stalls, plus two long hold-offs that back the
  // block up until it refuses commands.
  initial begin
    int   stall, burst, taken;
    res_t got;
    burst = 0;
    taken = 0;
    res_bus.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      stall = draw_gap(burst);
      if (taken == 120 || taken == 400) stall = 80;
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!res_bus.valid);
      got.dest_x = res_bus.dest_x;
      got.dest_y = res_bus.dest_y;
      got.src_x = res_bus.src_x;
      got.src_y = res_bus.src_y;
      got.copy_w = res_bus.copy_w;
      got.copy_h = res_bus.copy_h;
      got.placed_x = res_bus.placed_x;
      got.placed_y = res_bus.placed_y;
      tracker.check_placement(got);
      taken++;
    end
  end

  // Command side and run control.
  initial begin
    cmd_t plan[$];
    cmd_t c;
    int   counted;
    bit   drained;
    tracker = new();
    cycles <= 0;
    send_burst = 0;
    drained = 1'b0;
    rst_ni <= 1'b0;
    cmd_bus.valid <= 1'b0;
    cmd_bus.action <= ACT_SET_POS;
    cmd_bus.new_x <= '0;
    cmd_bus.new_y <= '0;
    cmd_bus.drift_dir <= DRIFT_NONE;
    cmd_bus.mode_value <= MODE_CLAMP;
    cmd_bus.sprite_width <= '0;
    cmd_bus.sprite_height <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: auto center from reset, size extremes and saturation,
    // zero size, drift codes that must not leave auto center.
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 1, 1));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, SCREEN_W, SCREEN_H));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 511, 255));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_SET_DX, 5, 5, DRIFT_NONE, MODE_WRAP, 3, 3));
    plan.push_back(mk(ACT_SET_DY, 5, 5, 2'b11, MODE_WRAP, 3, 3));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 17, 9));
    // set position leaves auto center; clamp at both position extremes
    plan.push_back(mk(ACT_SET_POS, -32768, 32767, DRIFT_NONE, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 10, 10));
    // wrap: past the right edge and above the top edge
    plan.push_back(mk(ACT_SET_MODE, 0, 0, DRIFT_NONE, MODE_WRAP, 0, 0));
    plan.push_back(mk(ACT_SET_POS, 321, -6, DRIFT_NONE, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 5, 5));
    // drift across the 16-bit wrap in both directions
    plan.push_back(mk(ACT_SET_POS, 32767, -32768, DRIFT_NONE, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_SET_DX, 0, 0, DRIFT_PLUS, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_SET_DY, 0, 0, DRIFT_MINUS, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 1, 1));
    // keep inside
    plan.push_back(mk(ACT_SET_MODE, 0, 0, DRIFT_NONE, MODE_INSIDE, 0, 0));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, SCREEN_W, SCREEN_H));
    plan.push_back(mk(ACT_SET_POS, 400, -3, DRIFT_NONE, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, 100, 50));
    // undefined actions with every field bit set
    plan.push_back(mk(ACT_DRAW | 3'($urandom_range(1, 3)), -1, -1, 2'b11, 2'b11, 511, 255));
    plan.push_back(mk(ACT_DRAW | 3'($urandom_range(1, 3)), -1, -1, 2'b11, 2'b11, 511, 255));
    // a moving drift leaves auto center
    plan.push_back(mk(ACT_SET_MODE, 0, 0, DRIFT_NONE, MODE_CENTRE, 0, 0));
    plan.push_back(mk(ACT_SET_DY, 0, 0, DRIFT_MINUS, MODE_CLAMP, 0, 0));
    plan.push_back(mk(ACT_DRAW, 0, 0, DRIFT_NONE, MODE_CLAMP, SCREEN_W, SCREEN_H));
    foreach (plan[i]) send_word(plan[i]);

    counted = 0;
    while (counted < RANDOM_WORDS) begin
      // one full drain midway: sender waits for every placement owed
      if (counted == RANDOM_WORDS / 2 && !drained) begin
        drained = 1'b1;
        cmd_bus.valid <= 1'b0;
        do @(posedge clk_i); while (tracker.due.size() != 0);
      end
      c = rand_word();
      if (c.action <= ACT_DRAW) counted++;
      send_word(c);
    end
    cmd_bus.valid <= 1'b0;

    do @(posedge clk_i); while (tracker.due.size() != 0);
    // command and result registers; extra cycles catch any stray placement word
    repeat (10) @(posedge clk_i);
    if (tracker.due.size() != 0)
      $display("%0t: %0d placement words never arrived", $time, tracker.due.size());
    if (tracker.mismatches == 0 && tracker.due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
